// ----- design/dirty_region_tile_clear_top_defines.svh -----
// Assertion helpers shared by the modules that check their own logic.
// Each expects the module to have ports named clk and arst_n.
`ifndef DIRTY_REGION_TILE_CLEAR_TOP_DEFINES_SVH
`define DIRTY_REGION_TILE_CLEAR_TOP_DEFINES_SVH

// Same-cycle implication.
`define DRTC_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DRTC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/drtc_pkg.sv -----
`timescale 1ns / 1ps

package drtc_pkg;

	localparam int HISTORY_FRAMES = 2;
	localparam int MAX_RESULTS    = 4;
	localparam int QUEUE_DEPTH    = 8;
	localparam int PTR_W          = $clog2(QUEUE_DEPTH);
	localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);
	localparam int PUSH_W         = $clog2(MAX_RESULTS + 1);

	typedef logic signed [14:0] coord_t;
	typedef logic signed [15:0] dim_t;
	typedef logic signed [17:0] wide_t;

	localparam coord_t EMPTY_LO       = 15'sd9999;
	localparam coord_t EMPTY_HI       = -15'sd9999;
	localparam logic [7:0] FULL_VIEW_SIZE = 8'd120;
	localparam wide_t SAT_MAX         = 18'sd32767;
	localparam wide_t SAT_MIN         = -18'sd32768;

	typedef enum logic [1:0] {
		MODE_POINT  = 2'd0,
		MODE_SCREEN = 2'd1,
		MODE_END    = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_SCREEN_W = 3'd0,
		REG_SCREEN_H = 3'd1,
		REG_VIEW_L   = 3'd2,
		REG_VIEW_T   = 3'd3,
		REG_VIEW_W   = 3'd4,
		REG_VIEW_H   = 3'd5,
		REG_VIEW_SZ  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		coord_t x1;
		coord_t y1;
		coord_t x2;
		coord_t y2;
	} box_t;

	typedef struct packed {
		logic [12:0] left;
		logic [12:0] top;
		logic [13:0] width;
		logic [13:0] height;
	} view_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		dim_t   w;
		dim_t   h;
		logic   last;
	} rect_t;

	typedef struct packed {
		logic [MAX_RESULTS-1:0] valid;
		rect_t [MAX_RESULTS-1:0] rect;
	} push_t;

	function automatic dim_t sat16(input wide_t v);
		dim_t r;
		if (v > SAT_MAX) begin
			r = 16'sh7fff;
		end else if (v < SAT_MIN) begin
			r = -16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic rect_t make_rect(input wide_t x, input wide_t y,
			input wide_t w, input wide_t h);
		rect_t r;
		r.x    = x[14:0];
		r.y    = y[14:0];
		r.w    = sat16(w);
		r.h    = sat16(h);
		r.last = 1'b0;
		return r;
	endfunction

endpackage

// ----- design/drtc_rects.sv -----
`timescale 1ns / 1ps

// Union of the current and history boxes, then the four trimming steps
// around the viewport. Purely combinational, sits after the input stage.
module drtc_rects import drtc_pkg::*; (
	input  logic  en,
	input  box_t  cur,
	input  box_t  hist [HISTORY_FRAMES],
	input  view_t view,
	output push_t push
);

	box_t  u;
	wide_t top_w, bot_w, left_w, right_w;
	wide_t cx1, cy1, cx2, cy2, t;
	logic  go;
	logic  [MAX_RESULTS-1:0] v;
	rect_t [MAX_RESULTS-1:0] r;
	logic  seen;

	always_comb begin
		u = cur;
		for (int k = 0; k < HISTORY_FRAMES; k++) begin
			if (hist[k].x1 < u.x1) u.x1 = hist[k].x1;
			if (hist[k].x2 > u.x2) u.x2 = hist[k].x2;
			if (hist[k].y1 < u.y1) u.y1 = hist[k].y1;
			if (hist[k].y2 > u.y2) u.y2 = hist[k].y2;
		end
		go = en && (u.y2 > u.y1);

		top_w   = $signed({5'b0, view.top});
		bot_w   = top_w + $signed({4'b0, view.height}) - 18'sd1;
		left_w  = $signed({5'b0, view.left});
		right_w = left_w + $signed({4'b0, view.width}) - 18'sd1;

		cx1 = wide_t'(u.x1);
		cy1 = wide_t'(u.y1);
		cx2 = wide_t'(u.x2);
		cy2 = wide_t'(u.y2);

		// Band above the viewport.
		v[0] = cy1 < top_w;
		t    = (cy2 < top_w - 18'sd1) ? cy2 : top_w - 18'sd1;
		r[0] = make_rect(cx1, cy1, cx2 - cx1 + 18'sd1, t - cy1 + 18'sd1);
		if (v[0]) cy1 = top_w;

		// Band below.
		v[1] = cy2 > bot_w;
		t    = (cy1 > bot_w + 18'sd1) ? cy1 : bot_w + 18'sd1;
		r[1] = make_rect(cx1, t, cx2 - cx1 + 18'sd1, cy2 - t + 18'sd1);
		if (v[1]) cy2 = bot_w;

		// Strip to the left.
		v[2] = cx1 < left_w;
		t    = (cx2 < left_w - 18'sd1) ? cx2 : left_w - 18'sd1;
		r[2] = make_rect(cx1, cy1, t - cx1 + 18'sd1, cy2 - cy1 + 18'sd1);
		if (v[2]) cx1 = left_w;

		// Strip to the right.
		v[3] = cx2 > right_w;
		t    = (cx1 > right_w + 18'sd1) ? cx1 : right_w + 18'sd1;
		r[3] = make_rect(t, cy1, cx2 - t + 18'sd1, cy2 - cy1 + 18'sd1);

		push.valid = go ? v : '0;
		seen = 1'b0;
		for (int k = MAX_RESULTS - 1; k >= 0; k--) begin
			r[k].last = push.valid[k] && !seen;
			seen      = seen || push.valid[k];
		end
		push.rect = r;
	end

endmodule

// ----- design/drtc_rqueue.sv -----
`timescale 1ns / 1ps

`include "dirty_region_tile_clear_top_defines.svh"

// Result queue: takes up to MAX_RESULTS rectangles a cycle, in order, and
// hands them out one beat at a time.
module drtc_rqueue import drtc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output rect_t out_rect
);

	rect_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [PUSH_W-1:0] push_num;
	logic [PTR_W-1:0]  widx [MAX_RESULTS];
	logic              pop;

	always_comb begin
		push_num = '0;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			widx[k]  = wptr_q + PTR_W'(push_num);
			push_num = push_num + PUSH_W'(push.valid[k]);
		end
	end

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign out_rect  = mem_q[rptr_q];
	assign room      = count_q <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS);

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (push.valid[k]) mem_q[widx[k]] <= push.rect[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PTR_W'(push_num);
			rptr_q  <= rptr_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push_num) - CNT_W'(pop);
		end
	end

	`DRTC_ASSERT_IMPL(a_cnt_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
	`DRTC_ASSERT_IMPL(a_no_ovf, push_num != '0, (count_q + CNT_W'(push_num)) <= CNT_W'(QUEUE_DEPTH), "queue overflow")
	`DRTC_ASSERT_NEXT(a_pop_only, pop && push_num == '0, count_q == $past(count_q) - 1'b1, "pop count slip")

endmodule

// ----- design/dirty_region_tile_clear_top.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Beat contents
// s_*     | in        | one command: kind on tuser, point on tdata
// m_*     | out       | one clear rectangle, tlast on the last of a frame end
// cfg_*   | in        | one register write (index, data)
//
// An accepted command waits in the input stage until the queue has four free entries,
// then is applied; any rectangles enter the result queue as it is applied and are
// presented from the queue's registers. A command is taken every cycle unless the
// input stage is holding one while the queue has fewer than four free entries; a
// frame end of n rectangles takes n output beats to drain.
// Reset empties the dirty box, zeroes the history and restores register defaults.
module dirty_region_tile_clear_top import drtc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // point_x[14:0], point_y[29:15], zeros above
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // rect_x[14:0], rect_y[29:15], rect_width[45:30],
	                               // rect_height[61:46], zeros above
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	// Configuration registers.
	logic [13:0] screen_w_q, screen_h_q;
	view_t       view_q;
	logic [7:0]  view_size_q;

	// Input stage.
	logic        valid_s1;
	logic [1:0]  mode_s1;
	coord_t      px_s1, py_s1;

	// Dirty box and the boxes of previous frames.
	box_t        cur_q;
	box_t        hist_q [HISTORY_FRAMES];

	logic        room, adv, full_view, end_go;
	push_t       push;
	rect_t       out_rect;
	coord_t      sw1, sh1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q   <= 14'd640;
			screen_h_q   <= 14'd480;
			view_q.left  <= '0;
			view_q.top   <= '0;
			view_q.width <= 14'd640;
			view_q.height <= 14'd480;
			view_size_q  <= FULL_VIEW_SIZE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_W: screen_w_q    <= cfg_data;
				REG_SCREEN_H: screen_h_q    <= cfg_data;
				REG_VIEW_L:   view_q.left   <= cfg_data[12:0];
				REG_VIEW_T:   view_q.top    <= cfg_data[12:0];
				REG_VIEW_W:   view_q.width  <= cfg_data;
				REG_VIEW_H:   view_q.height <= cfg_data;
				REG_VIEW_SZ:  view_size_q   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// The input stage moves on whenever the queue can take a full frame end.
	assign adv      = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			px_s1   <= s_tdata[14:0];
			py_s1   <= s_tdata[29:15];
		end
	end

	assign full_view = view_size_q >= FULL_VIEW_SIZE;
	assign end_go    = adv && (mode_s1 == MODE_END) && !full_view;
	assign sw1       = $signed({1'b0, screen_w_q}) - 15'sd1;
	assign sh1       = $signed({1'b0, screen_h_q}) - 15'sd1;

	drtc_rects u_rects (
		.en   (end_go),
		.cur  (cur_q),
		.hist (hist_q),
		.view (view_q),
		.push (push)
	);

	// Box state: widen on points and whole-screen dirties; on a frame end, unless
	// the view is full, the current box enters the history and starts over empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '{x1: EMPTY_LO, y1: EMPTY_LO, x2: EMPTY_HI, y2: EMPTY_HI};
			for (int k = 0; k < HISTORY_FRAMES; k++) hist_q[k] <= '0;
		end else if (adv) begin
			case (mode_s1)
				MODE_POINT: begin
					if (px_s1 < cur_q.x1) cur_q.x1 <= px_s1;
					if (px_s1 > cur_q.x2) cur_q.x2 <= px_s1;
					if (py_s1 < cur_q.y1) cur_q.y1 <= py_s1;
					if (py_s1 > cur_q.y2) cur_q.y2 <= py_s1;
				end
				MODE_SCREEN: begin
					cur_q.x1 <= (sw1 < cur_q.x1 && sw1 < 15'sd0) ? sw1 :
						(cur_q.x1 < 15'sd0 ? cur_q.x1 : 15'sd0);
					cur_q.y1 <= (sh1 < cur_q.y1 && sh1 < 15'sd0) ? sh1 :
						(cur_q.y1 < 15'sd0 ? cur_q.y1 : 15'sd0);
					cur_q.x2 <= (sw1 > cur_q.x2 && sw1 > 15'sd0) ? sw1 :
						(cur_q.x2 > 15'sd0 ? cur_q.x2 : 15'sd0);
					cur_q.y2 <= (sh1 > cur_q.y2 && sh1 > 15'sd0) ? sh1 :
						(cur_q.y2 > 15'sd0 ? cur_q.y2 : 15'sd0);
				end
				MODE_END: begin
					if (!full_view) begin
						for (int k = HISTORY_FRAMES - 1; k > 0; k--) hist_q[k] <= hist_q[k-1];
						hist_q[0] <= cur_q;
						cur_q <= '{x1: EMPTY_LO, y1: EMPTY_LO, x2: EMPTY_HI, y2: EMPTY_HI};
					end
				end
				default: begin
				end
			endcase
		end
	end

	drtc_rqueue u_rqueue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rect  (out_rect)
	);

	assign m_tdata = {2'b00, out_rect.h, out_rect.w, out_rect.y, out_rect.x};
	assign m_tlast = out_rect.last;

	`DRTC_ASSERT_NEXT(a_end_clears, end_go, cur_q.x1 == EMPTY_LO && cur_q.y2 == EMPTY_HI, "box not cleared at frame end")
	`DRTC_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(mode_s1) && $stable(px_s1), "input stage lost a stalled item")
	`DRTC_ASSERT_NEXT(a_point_in, adv && mode_s1 == MODE_POINT, cur_q.x1 <= $past(px_s1) && cur_q.x2 >= $past(px_s1), "point outside widened box")

endmodule

// ----- test/dirty_region_tile_clear_top_test.sv -----
`timescale 1ns / 1ps

module dirty_region_tile_clear_top_test;
	import drtc_pkg::*;

	localparam int          CLK_PERIOD  = 10;
	// Cycles the block may still be busy after the last rectangle has left it.
	localparam int          SETTLE      = 8;
	localparam int          HOLD_CYCLES = 80;
	localparam int          PHASES      = 7;
	localparam int          PHASE_ITEMS = 14;
	localparam int          NUM_REGS    = 7;
	localparam int          N_ROWS      = 36;
	localparam longint      LIMIT_NS    = 3_000_000;
	localparam logic [1:0]  MODE_UNUSED = 2'd3;
	localparam logic [2:0]  REG_UNUSED  = 3'd7;

	// A dirty box in plain integers, so that unions and trims cannot overflow.
	typedef struct {
		int x1;
		int y1;
		int x2;
		int y2;
	} extent_t;

	// One line of the directed script: either a register write or a command.
	// For a command, rects gives the number of rectangle beats it must yield,
	// or -1 where only the predictor knows.
	typedef struct {
		bit          is_reg;
		logic [2:0]  index;
		logic [13:0] value;
		logic [1:0]  mode;
		int          px;
		int          py;
		int          rects;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // point_x[14:0], point_y[29:15], zeros above
	logic [1:0]  s_tuser;    // mode[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;    // rect_x[14:0], rect_y[29:15], rect_width[45:30],
	                         // rect_height[61:46], zeros above
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [13:0] cfg_data;

	dirty_region_tile_clear_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Our own copy of the block's state and registers.
	extent_t     live_box;
	extent_t     past_box [HISTORY_FRAMES];
	logic [13:0] pred_screen_w;
	logic [13:0] pred_screen_h;
	logic [12:0] vw_left;
	logic [12:0] vw_top;
	logic [13:0] vw_width;
	logic [13:0] vw_height;
	logic [7:0]  vw_size;

	// Clear rectangles still owed by the block, oldest first.
	rect_t rects_due [$];

	int faults;
	int items_taken;
	int frames_closed;
	int rects_seen;
	int input_stalls;

	// Sender burst state, and the flags that shape back-pressure.
	int          burst_left;
	bit          steady;
	bit          hold_off;
	logic [13:0] setting [NUM_REGS];

	// The directed script. It opens straight after reset, with the full-screen view
	// size, then exercises the empty union, extreme points with saturated widths,
	// the history rolling out over two frames, a box wholly inside the viewport,
	// the view size boundary, an unknown register, a zero-height viewport and a
	// zero-width screen.
	step_t script [N_ROWS] = '{
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      0},
		'{1'b1, REG_VIEW_SZ,  14'd0,    MODE_POINT,  0,      0,      -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      0},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_UNUSED, 16383,  -16384, 0},
		'{1'b1, REG_VIEW_L,   14'd100,  MODE_POINT,  0,      0,      -1},
		'{1'b1, REG_VIEW_T,   14'd100,  MODE_POINT,  0,      0,      -1},
		'{1'b1, REG_VIEW_W,   14'd200,  MODE_POINT,  0,      0,      -1},
		'{1'b1, REG_VIEW_H,   14'd200,  MODE_POINT,  0,      0,      -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_POINT,  -16384, -16384, -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_POINT,  16383,  16383,  -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      4},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      4},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      4},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      0},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_POINT,  150,    150,    -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_POINT,  250,    250,    -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      0},
		'{1'b1, REG_SCREEN_W, 14'd8192, MODE_POINT,  0,      0,      -1},
		'{1'b1, REG_SCREEN_H, 14'd1,    MODE_POINT,  0,      0,      -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_SCREEN, 0,      0,      -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      -1},
		'{1'b1, REG_VIEW_SZ,  14'd120,  MODE_POINT,  0,      0,      -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_POINT,  0,      0,      -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_POINT,  -1,     -1,     -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      0},
		'{1'b1, REG_VIEW_SZ,  14'd255,  MODE_POINT,  0,      0,      -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      0},
		'{1'b1, REG_VIEW_SZ,  14'd119,  MODE_POINT,  0,      0,      -1},
		'{1'b1, REG_UNUSED,   14'h3fff, MODE_POINT,  0,      0,      -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      -1},
		'{1'b1, REG_VIEW_H,   14'd0,    MODE_POINT,  0,      0,      -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_POINT,  50,     500,    -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      -1},
		'{1'b1, REG_SCREEN_W, 14'd0,    MODE_POINT,  0,      0,      -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_SCREEN, 0,      0,      -1},
		'{1'b0, REG_SCREEN_W, 14'd0,    MODE_END,    0,      0,      -1}
	};

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run, even with every stall at its longest.
	initial begin
		#(LIMIT_NS);
		$display("%0t: timed out with %0d rectangles outstanding", $time, rects_due.size());
		$display("CHECK FAILED");
		$finish;
	end

	// Widens the live box to take in one point.
	function automatic void take_point(int x, int y);
		if (x < live_box.x1) live_box.x1 = x;
		if (x > live_box.x2) live_box.x2 = x;
		if (y < live_box.y1) live_box.y1 = y;
		if (y > live_box.y2) live_box.y2 = y;
	endfunction

	// Width and height leave the block saturated to sixteen signed bits.
	function automatic dim_t clamp_dim(int v);
		dim_t r;
		if (v > 32767) begin
			r = 16'sh7fff;
		end else if (v < -32768) begin
			r = 16'sh8000;
		end else begin
			r = dim_t'(v);
		end
		return r;
	endfunction

	function automatic rect_t clear_rect(int x, int y, int w, int h);
		rect_t r;
		r.x    = coord_t'(x);
		r.y    = coord_t'(y);
		r.w    = clamp_dim(w);
		r.h    = clamp_dim(h);
		r.last = 1'b0;
		return r;
	endfunction

	// End of frame: union the live box with the history, roll the history on, and
	// cut the union into the bands above, below, left and right of the viewport.
	// Each band trims the union before the next is considered.
	function automatic void close_frame();
		extent_t u;
		int      k;
		int      top;
		int      bottom;
		int      left;
		int      right;
		int      span;
		int      t;
		rect_t   found [$];

		if (vw_size >= FULL_VIEW_SIZE) return;

		u = live_box;
		for (k = 0; k < HISTORY_FRAMES; k++) begin
			if (past_box[k].x1 < u.x1) u.x1 = past_box[k].x1;
			if (past_box[k].x2 > u.x2) u.x2 = past_box[k].x2;
			if (past_box[k].y1 < u.y1) u.y1 = past_box[k].y1;
			if (past_box[k].y2 > u.y2) u.y2 = past_box[k].y2;
		end
		for (k = HISTORY_FRAMES - 1; k > 0; k--) past_box[k] = past_box[k - 1];
		past_box[0] = live_box;
		live_box    = '{EMPTY_LO, EMPTY_LO, EMPTY_HI, EMPTY_HI};

		// Nothing disturbed: the history has still moved on.
		if (u.y2 <= u.y1) return;

		top    = vw_top;
		span   = vw_height;
		bottom = top + span - 1;
		left   = vw_left;
		span   = vw_width;
		right  = left + span - 1;

		if (u.y1 < top) begin
			t = (u.y2 < top - 1) ? u.y2 : top - 1;
			found.push_back(clear_rect(u.x1, u.y1, u.x2 - u.x1 + 1, t - u.y1 + 1));
			u.y1 = top;
		end
		if (u.y2 > bottom) begin
			t = (u.y1 > bottom + 1) ? u.y1 : bottom + 1;
			found.push_back(clear_rect(u.x1, t, u.x2 - u.x1 + 1, u.y2 - t + 1));
			u.y2 = bottom;
		end
		if (u.x1 < left) begin
			t = (u.x2 < left - 1) ? u.x2 : left - 1;
			found.push_back(clear_rect(u.x1, u.y1, t - u.x1 + 1, u.y2 - u.y1 + 1));
			u.x1 = left;
		end
		if (u.x2 > right) begin
			t = (u.x1 > right + 1) ? u.x1 : right + 1;
			found.push_back(clear_rect(t, u.y1, u.x2 - t + 1, u.y2 - u.y1 + 1));
			u.x2 = right;
		end
		if (found.size() > 0) found[found.size() - 1].last = 1'b1;
		foreach (found[i]) rects_due.push_back(found[i]);
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			faults++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Register writes are mirrored into the predictor as the block takes them.
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_W: pred_screen_w = cfg_data;
				REG_SCREEN_H: pred_screen_h = cfg_data;
				REG_VIEW_L:   vw_left       = cfg_data[12:0];
				REG_VIEW_T:   vw_top        = cfg_data[12:0];
				REG_VIEW_W:   vw_width      = cfg_data;
				REG_VIEW_H:   vw_height     = cfg_data;
				REG_VIEW_SZ:  vw_size       = cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Every command beat the block accepts is run through the predictor, and the
	// rectangles it owes are queued up behind the earlier ones.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && !s_tready) input_stalls++;
		if (arst_n && s_tvalid && s_tready) begin
			items_taken++;
			case (s_tuser)
				MODE_POINT: take_point($signed(s_tdata[14:0]), $signed(s_tdata[29:15]));
				MODE_SCREEN: begin
					take_point(0, 0);
					take_point(int'(pred_screen_w) - 1, int'(pred_screen_h) - 1);
				end
				MODE_END: begin
					close_frame();
					frames_closed++;
				end
				default: ;
			endcase
		end
	end

	// Each rectangle beat is held against the oldest one owed, field by field.
	always @(posedge clk) begin : rect_check
		rect_t want;
		if (arst_n && m_tvalid && m_tready) begin
			rects_seen++;
			if (rects_due.size() == 0) begin
				faults++;
				$display("%0t: rectangle beat with none expected, tdata %h", $time, m_tdata);
			end else begin
				want = rects_due.pop_front();
				compare_field("rect_x", want.x, $signed(m_tdata[14:0]));
				compare_field("rect_y", want.y, $signed(m_tdata[29:15]));
				compare_field("rect_width", want.w, $signed(m_tdata[45:30]));
				compare_field("rect_height", want.h, $signed(m_tdata[61:46]));
				compare_field("tdata padding", 0, m_tdata[63:62]);
				compare_field("last_rect", want.last, m_tlast);
			end
		end
	end

	// The receiver runs its own stall pattern: stretches of steady acceptance,
	// random stalls and a mostly-stalled rhythm. On request it holds off for a
	// long, counted stretch so that the result queue fills and the input stalls.
	initial begin : receiver
		int tick;
		m_tready = 1'b0;
		tick     = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				case ((tick / 50) % 3)
					0:       m_tready <= 1'b1;
					1:       m_tready <= ($urandom_range(0, 2) != 0);
					default: m_tready <= ((tick % 5) < 2);
				endcase
				tick++;
			end
		end
	end

	// Offers one command beat and waits until it is taken. Unless the sender is
	// told to keep going, beats come in bursts of random length with random gaps
	// between them, and some bursts follow on with no gap at all.
	task automatic send_cmd(input logic [1:0] mode, input int px, input int py);
		int gap;
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {2'b00, py[14:0], px[14:0]};
		do @(posedge clk); while (!s_tready);
	endtask

	// Keeps the write channel valid when another write follows straight on.
	task automatic write_reg(input logic [2:0] index, input logic [13:0] value, input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (!more) cfg_valid <= 1'b0;
	endtask

	// Writes every register, then an index that the block must ignore.
	task automatic program_regs(input logic [13:0] vals [NUM_REGS]);
		for (int r = 0; r < NUM_REGS; r++) write_reg(3'(r), vals[r], 1'b1);
		write_reg(REG_UNUSED, 14'($urandom), 1'b0);
	endtask

	// Stops offering commands until every rectangle owed has arrived and the
	// block has had time to finish any command that yields none.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (rects_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly near the viewport so that every band gets cut; now and then any
	// fifteen-bit value at all.
	function automatic int pick_coord(int origin);
		logic [14:0] raw;
		raw = 15'($urandom);
		if ($urandom_range(0, 4) == 0) return $signed(raw);
		return origin + int'($urandom_range(0, 1000)) - 300;
	endfunction

	initial begin : stimulus
		step_t row;
		int    base;
		int    sent;
		int    n_pts;

		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		hold_off   = 1'b0;
		steady     = 1'b0;
		burst_left = 0;
		faults     = 0;

		// The predictor starts where the block's reset leaves it.
		live_box   = '{EMPTY_LO, EMPTY_LO, EMPTY_HI, EMPTY_HI};
		foreach (past_box[k]) past_box[k] = '{0, 0, 0, 0};
		pred_screen_w = 14'd640;
		pred_screen_h = 14'd480;
		vw_left    = '0;
		vw_top     = '0;
		vw_width   = 14'd640;
		vw_height  = 14'd480;
		vw_size    = FULL_VIEW_SIZE;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Rows with a known beat count are run on their own, so
		// that the beats counted afterwards belong to that row alone.
		foreach (script[i]) begin
			row = script[i];
			if (row.is_reg) begin
				wait_idle();
				write_reg(row.index, row.value, 1'b0);
			end else if (row.rects < 0) begin
				send_cmd(row.mode, row.px, row.py);
			end else begin
				wait_idle();
				base = rects_seen;
				send_cmd(row.mode, row.px, row.py);
				wait_idle();
				if (rects_seen - base != row.rects) begin
					faults++;
					$display("%0t: script row %0d, expected %0d rectangles, actual %0d",
						$time, i, row.rects, rects_seen - base);
				end
			end
		end

		// Random part, in phases with a fresh register setting each time. The
		// first three phases hold the extremes: all zeros, all ones, and the
		// largest legal viewport with clearing switched on.
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: foreach (setting[r]) setting[r] = '0;
				1: foreach (setting[r]) setting[r] = '1;
				2: setting = '{14'd8192, 14'd8192, 14'd8191, 14'd8191, 14'd8192, 14'd8192, 14'd0};
				3: foreach (setting[r]) setting[r] = 14'($urandom);
				default: begin
					setting[REG_SCREEN_W] = 14'($urandom_range(1, 1024));
					setting[REG_SCREEN_H] = 14'($urandom_range(1, 1024));
					setting[REG_VIEW_L]   = 14'($urandom_range(0, 600));
					setting[REG_VIEW_T]   = 14'($urandom_range(0, 600));
					setting[REG_VIEW_W]   = 14'($urandom_range(0, 700));
					setting[REG_VIEW_H]   = 14'($urandom_range(0, 700));
					setting[REG_VIEW_SZ]  = ($urandom_range(0, 3) == 0) ?
						14'($urandom_range(120, 255)) : 14'($urandom_range(0, 119));
				end
			endcase
			program_regs(setting);

			// Mostly whole frames of a few points closed by an end of frame, with
			// screen dirties, bare frame ends and unused commands mixed in.
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				n_pts = $urandom_range(0, 5);
				repeat (n_pts) begin
					send_cmd(MODE_POINT, pick_coord(vw_left), pick_coord(vw_top));
					sent++;
				end
				if ($urandom_range(0, 5) == 0) begin
					send_cmd(MODE_SCREEN, $urandom, $urandom);
					sent++;
				end
				if ($urandom_range(0, 7) == 0) send_cmd(MODE_UNUSED, $urandom, $urandom);
				send_cmd(MODE_END, $urandom, $urandom);
				sent++;
			end
		end

		// Back-pressure: the receiver holds off while the sender keeps offering
		// frames that each yield four rectangles, so the block must stall its input.
		wait_idle();
		setting = '{14'd640, 14'd480, 14'd100, 14'd100, 14'd50, 14'd50, 14'd0};
		program_regs(setting);
		steady   = 1'b1;
		hold_off = 1'b1;
		repeat (10) begin
			send_cmd(MODE_POINT, -500, -500);
			send_cmd(MODE_POINT, 900, 900);
			send_cmd(MODE_END, 0, 0);
		end
		steady = 1'b0;

		wait_idle();
		$display("Run covered %0d command beats, %0d frame ends and %0d rectangle beats.",
			items_taken, frames_closed, rects_seen);
		$display("Input was held back for %0d cycles; %0d mismatches were found.",
			input_stalls, faults);
		if (faults == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
